@@ design/wpsa_pkg.sv @@
// Shared types and constants for the weighted posterior scatter-accumulate block.
// Depends on nothing; every other file refers to it by scoped names.

package wpsa_pkg;

    // Matrix and map geometry
    localparam int MAX_COLS    = 256;
    localparam int MAX_SEQ_LEN = 256;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int SEQ_W       = $clog2(MAX_SEQ_LEN);
    localparam int CELL_AW     = 2 * COL_W;
    localparam int CELL_DEPTH  = MAX_COLS * MAX_COLS;

    // Field widths
    localparam int POS_W   = 8;
    localparam int CFG_W   = 9;
    localparam int FRAC_W  = 16;
    localparam int CELL_W  = 32;
    localparam int WW_W    = 2 * FRAC_W;
    localparam int PROD_W  = 3 * FRAC_W;
    localparam int SHIFT   = 24;
    localparam int INC_W   = PROD_W - SHIFT + 1;

    localparam logic [POS_W:0]  SEQ_LIMIT  = (POS_W + 1)'(MAX_SEQ_LEN);
    localparam logic [CFG_W-1:0] COL_LIMIT = CFG_W'(MAX_COLS);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SHIFT - 1);
    localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELL_DEPTH - 1);

    // Depth of both queues
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input op codes
    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_LOAD_A = 3'd1,
        OP_LOAD_B = 3'd2,
        OP_ACCUM  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    // Command kinds after classification
    typedef enum logic [2:0] {
        CMD_NOP    = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_LOAD_A = 3'd2,
        CMD_LOAD_B = 3'd3,
        CMD_ACCUM  = 3'd4,
        CMD_READ   = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               pos_err;
        logic [POS_W-1:0]   a_pos;
        logic [POS_W-1:0]   b_pos;
        logic [COL_W-1:0]   map_col;
        logic [COL_W-1:0]   cell_row;
        logic [COL_W-1:0]   cell_col;
        logic [FRAC_W-1:0]  prob;
        logic [FRAC_W-1:0]  weight_one;
        logic [FRAC_W-1:0]  weight_two;
    } cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic              status;
    } res_t;

    typedef struct packed {
        logic empty;
        logic full;
    } resq_stat_t;

    typedef struct packed {
        logic take;
        logic init_busy;
    } back_ctl_t;

endpackage

@@ design/wpsa_front.sv @@
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on wpsa_pkg.

module wpsa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [2:0]                    op,
    input  logic [7:0]                    row_pos,
    input  logic [7:0]                    col_pos,
    input  logic                          swapped,
    input  logic [15:0]                   prob,
    input  logic [15:0]                   weight_one,
    input  logic [15:0]                   weight_two,
    input  logic [7:0]                    map_col,
    input  logic [7:0]                    cell_row,
    input  logic [7:0]                    cell_col,
    input  wpsa_pkg::back_ctl_t           ctl,
    output logic                          cmd_valid,
    output wpsa_pkg::cmd_t                cmd
);

    wpsa_pkg::cmd_t                    q_mem [wpsa_pkg::QUEUE_DEPTH];
    logic [wpsa_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [wpsa_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [wpsa_pkg::QCNT_W-1:0]       count_reg, count_next;
    wpsa_pkg::cmd_t                    cls;
    logic                              accept;

    // Classify the incoming item
    always_comb
    begin
        cls            = '0;
        cls.kind       = wpsa_pkg::CMD_NOP;
        cls.map_col    = map_col;
        cls.cell_row   = cell_row;
        cls.cell_col   = cell_col;
        cls.prob       = prob;
        cls.weight_one = weight_one;
        cls.weight_two = weight_two;
        cls.a_pos      = row_pos;
        cls.b_pos      = col_pos;
        unique case (op)
            wpsa_pkg::OP_CLEAR:
            begin
                cls.kind = wpsa_pkg::CMD_CLEAR;
            end
            wpsa_pkg::OP_LOAD_A:
            begin
                cls.kind    = wpsa_pkg::CMD_LOAD_A;
                cls.pos_err = ({1'b0, row_pos} >= wpsa_pkg::SEQ_LIMIT);
            end
            wpsa_pkg::OP_LOAD_B:
            begin
                cls.kind    = wpsa_pkg::CMD_LOAD_B;
                cls.pos_err = ({1'b0, row_pos} >= wpsa_pkg::SEQ_LIMIT);
            end
            wpsa_pkg::OP_ACCUM:
            begin
                cls.kind    = wpsa_pkg::CMD_ACCUM;
                cls.a_pos   = swapped ? col_pos : row_pos;
                cls.b_pos   = swapped ? row_pos : col_pos;
                cls.pos_err = ({1'b0, row_pos} >= wpsa_pkg::SEQ_LIMIT) ||
                              ({1'b0, col_pos} >= wpsa_pkg::SEQ_LIMIT);
            end
            wpsa_pkg::OP_READ:
            begin
                cls.kind = wpsa_pkg::CMD_READ;
            end
            default:
            begin
                cls.kind = wpsa_pkg::CMD_NOP;
            end
        endcase
    end

    // Hold off input while the queue is full or the matrix is still being swept after reset
    assign full      = (count_reg == wpsa_pkg::QCNT_W'(wpsa_pkg::QUEUE_DEPTH)) || ctl.init_busy;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (ctl.take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (accept && !ctl.take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!accept && ctl.take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ design/wpsa_back.sv @@
// Back end: sequencer that owns the maps and the cell matrix and carries out commands.
// Depends on wpsa_pkg.

module wpsa_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  wpsa_pkg::cmd_t                    cmd,
    input  logic [wpsa_pkg::CFG_W-1:0]        rows_in_use,
    input  logic [wpsa_pkg::CFG_W-1:0]        cols_in_use,
    input  wpsa_pkg::resq_stat_t              res_stat,
    output wpsa_pkg::back_ctl_t               ctl,
    output logic                              res_push,
    output wpsa_pkg::res_t                    res
);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_CLEAR = 6'b000100,
        ST_MAP   = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_RDOUT = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic [wpsa_pkg::CELL_AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [wpsa_pkg::CELL_AW-1:0]        cell_addr_reg, cell_addr_next;
    logic [wpsa_pkg::FRAC_W-1:0]         prob_reg;
    logic [wpsa_pkg::WW_W-1:0]           ww_reg;
    logic [wpsa_pkg::PROD_W-1:0]         prod_reg;

    logic [wpsa_pkg::CELL_W-1:0]         cell_mem [wpsa_pkg::CELL_DEPTH];
    logic [wpsa_pkg::COL_W-1:0]          map_a_mem [wpsa_pkg::MAX_SEQ_LEN];
    logic [wpsa_pkg::COL_W-1:0]          map_b_mem [wpsa_pkg::MAX_SEQ_LEN];
    logic [wpsa_pkg::CELL_W-1:0]         cell_data_reg;
    logic [wpsa_pkg::COL_W-1:0]          map_a_data_reg;
    logic [wpsa_pkg::COL_W-1:0]          map_b_data_reg;

    logic                                start;
    logic                                map_a_we, map_b_we, map_rd;
    logic                                cell_we, cell_rd;
    logic [wpsa_pkg::CELL_AW-1:0]        cell_wr_addr, cell_rd_addr;
    logic [wpsa_pkg::CELL_W-1:0]         cell_wdata;
    logic                                map_ok, read_ok;
    logic [wpsa_pkg::PROD_W-1:0]         rounded;
    logic [wpsa_pkg::INC_W-1:0]          inc;
    logic [wpsa_pkg::CELL_W:0]           sum;
    logic [wpsa_pkg::CELL_W-1:0]         sat_sum;

    assign start = (state_reg == ST_IDLE) && cmd_valid && !res_stat.full;

    assign ctl.take      = start;
    assign ctl.init_busy = (state_reg == ST_INIT);

    // Bound checks against both the configured count and the matrix size
    assign map_ok  = ({1'b0, map_a_data_reg} < rows_in_use) &&
                     ({1'b0, map_a_data_reg} < wpsa_pkg::COL_LIMIT) &&
                     ({1'b0, map_b_data_reg} < cols_in_use) &&
                     ({1'b0, map_b_data_reg} < wpsa_pkg::COL_LIMIT);
    assign read_ok = ({1'b0, cmd.cell_row} < rows_in_use) &&
                     ({1'b0, cmd.cell_row} < wpsa_pkg::COL_LIMIT) &&
                     ({1'b0, cmd.cell_col} < cols_in_use) &&
                     ({1'b0, cmd.cell_col} < wpsa_pkg::COL_LIMIT);

    // Round Q0.48 to Q8.24, add, saturate
    assign rounded = prod_reg + wpsa_pkg::ROUND_HALF;
    assign inc     = rounded[wpsa_pkg::PROD_W-1:wpsa_pkg::SHIFT] == '0 ?
                     '0 : wpsa_pkg::INC_W'(rounded >> wpsa_pkg::SHIFT);
    assign sum     = {1'b0, cell_data_reg} + (wpsa_pkg::CELL_W + 1)'(inc);
    assign sat_sum = sum[wpsa_pkg::CELL_W] ? '1 : sum[wpsa_pkg::CELL_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cell_addr_next = cell_addr_reg;
        res_push       = 1'b0;
        res            = '0;
        map_a_we       = 1'b0;
        map_b_we       = 1'b0;
        map_rd         = 1'b0;
        cell_we        = 1'b0;
        cell_rd        = 1'b0;
        cell_wr_addr   = clr_addr_reg;
        cell_rd_addr   = {cmd.cell_row, cmd.cell_col};
        cell_wdata     = '0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // Sweep one cell per cycle
                cell_we       = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == wpsa_pkg::CELL_LAST)
                begin
                    state_next = ST_IDLE;
                    res_push   = (state_reg == ST_CLEAR);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.kind)
                        wpsa_pkg::CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        wpsa_pkg::CMD_LOAD_A:
                        begin
                            map_a_we   = !cmd.pos_err;
                            res_push   = 1'b1;
                            res.status = cmd.pos_err;
                        end
                        wpsa_pkg::CMD_LOAD_B:
                        begin
                            map_b_we   = !cmd.pos_err;
                            res_push   = 1'b1;
                            res.status = cmd.pos_err;
                        end
                        wpsa_pkg::CMD_ACCUM:
                        begin
                            if (cmd.pos_err)
                            begin
                                res_push   = 1'b1;
                                res.status = 1'b1;
                            end
                            else
                            begin
                                map_rd     = 1'b1;
                                state_next = ST_MAP;
                            end
                        end
                        wpsa_pkg::CMD_READ:
                        begin
                            if (read_ok)
                            begin
                                cell_rd    = 1'b1;
                                state_next = ST_RDOUT;
                            end
                            else
                            begin
                                res_push   = 1'b1;
                                res.status = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_MAP:
            begin
                if (map_ok)
                begin
                    cell_rd        = 1'b1;
                    cell_rd_addr   = {map_a_data_reg, map_b_data_reg};
                    cell_addr_next = {map_a_data_reg, map_b_data_reg};
                    state_next     = ST_ADD;
                end
                else
                begin
                    res_push   = 1'b1;
                    res.status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                cell_we      = 1'b1;
                cell_wr_addr = cell_addr_reg;
                cell_wdata   = sat_sum;
                res_push     = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_RDOUT:
            begin
                res_push   = 1'b1;
                res.value  = cell_data_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Payload registers and the two multiplier stages
    always_ff @(posedge clk)
    begin
        cell_addr_reg <= cell_addr_next;
        if (start)
        begin
            prob_reg <= cmd.prob;
            ww_reg   <= {{wpsa_pkg::FRAC_W{1'b0}}, cmd.weight_one} *
                        {{wpsa_pkg::FRAC_W{1'b0}}, cmd.weight_two};
        end
        if (state_reg == ST_MAP)
        begin
            prod_reg <= wpsa_pkg::PROD_W'(ww_reg) * wpsa_pkg::PROD_W'(prob_reg);
        end
    end

    // Cell matrix: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_wr_addr] <= cell_wdata;
        end
        if (cell_rd)
        begin
            cell_data_reg <= cell_mem[cell_rd_addr];
        end
    end

    // Maps: loads write at a_pos; an accumulate reads A at a_pos and B at b_pos
    always_ff @(posedge clk)
    begin
        if (map_a_we)
        begin
            map_a_mem[cmd.a_pos[wpsa_pkg::SEQ_W-1:0]] <= cmd.map_col;
        end
        if (map_rd)
        begin
            map_a_data_reg <= map_a_mem[cmd.a_pos[wpsa_pkg::SEQ_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_b_we)
        begin
            map_b_mem[cmd.a_pos[wpsa_pkg::SEQ_W-1:0]] <= cmd.map_col;
        end
        if (map_rd)
        begin
            map_b_data_reg <= map_b_mem[cmd.b_pos[wpsa_pkg::SEQ_W-1:0]];
        end
    end

endmodule

@@ design/wpsa_resq.sv @@
// Result queue: holds finished results until the consumer takes them.
// Depends on wpsa_pkg.

module wpsa_resq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_push,
    input  wpsa_pkg::res_t         res_in,
    input  logic                   pop,
    output wpsa_pkg::resq_stat_t   stat,
    output wpsa_pkg::res_t         res_out
);

    wpsa_pkg::res_t                q_mem [wpsa_pkg::QUEUE_DEPTH];
    logic [wpsa_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [wpsa_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [wpsa_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                          do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == wpsa_pkg::QCNT_W'(wpsa_pkg::QUEUE_DEPTH));
    assign do_pop     = pop && !stat.empty;
    assign res_out    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (res_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (res_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!res_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            q_mem[wr_ptr_reg] <= res_in;
        end
    end

endmodule

@@ design/weighted_posterior_scatter_accumulate.sv @@
// Weighted posterior scatter-accumulate, top level; uses wpsa_pkg, wpsa_front,
// wpsa_back and wpsa_resq. Items enter through a push/full queue port and every
// item yields exactly one result on the empty/pop side, in order. A 2-deep command
// queue decouples input from the sequencer, and a 2-deep result queue decouples the
// sequencer from the consumer. The sequencer carries out one item at a time and
// starts it only while the result queue has room. A load, an unused op or a cell
// read that fails its bound check pushes its result in its start cycle; a good cell
// read goes through the registered matrix read; an accumulate whose mapped row or
// column fails the bound check goes through the registered map read, then the
// reject; a good accumulate goes through the registered map read, then the
// registered cell read with the second multiply, then the saturating write back.
// A clear sweeps all 65536 cells, one per cycle, after its start cycle. After
// reset the same sweep runs before any item is accepted (full stays high);
// configuration writes are taken throughout.
// rows_in_use sits at byte address 0 and cols_in_use at 4, both 9 bits, reset 256.

module weighted_posterior_scatter_accumulate (
    input  logic        clk,
    input  logic        rst_n,
    // input side
    input  logic        push,
    output logic        full,
    input  logic [2:0]  op,
    input  logic [7:0]  row_pos,
    input  logic [7:0]  col_pos,
    input  logic        swapped,
    input  logic [15:0] prob,
    input  logic [15:0] weight_one,
    input  logic [15:0] weight_two,
    input  logic [7:0]  map_col,
    input  logic [7:0]  cell_row,
    input  logic [7:0]  cell_col,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [31:0] cell_value,
    output logic        status,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register indexes, taken from the word address bit
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    logic [wpsa_pkg::CFG_W-1:0]  rows_in_use_reg, rows_in_use_next;
    logic [wpsa_pkg::CFG_W-1:0]  cols_in_use_reg, cols_in_use_next;
    logic                        cfg_wr;

    logic                        cmd_valid;
    wpsa_pkg::cmd_t              cmd;
    wpsa_pkg::back_ctl_t         ctl;
    logic                        res_push;
    wpsa_pkg::res_t              res;
    wpsa_pkg::resq_stat_t        rq_stat;
    wpsa_pkg::res_t              rq_head;

    // Configuration registers: write on the access phase of a transfer
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        rows_in_use_next = rows_in_use_reg;
        cols_in_use_next = cols_in_use_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROWS: rows_in_use_next = pwdata[wpsa_pkg::CFG_W-1:0];
                REG_COLS: cols_in_use_next = pwdata[wpsa_pkg::CFG_W-1:0];
                default:  rows_in_use_next = rows_in_use_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS: prdata = {{(32 - wpsa_pkg::CFG_W){1'b0}}, rows_in_use_reg};
            REG_COLS: prdata = {{(32 - wpsa_pkg::CFG_W){1'b0}}, cols_in_use_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= wpsa_pkg::COL_LIMIT;
            cols_in_use_reg <= wpsa_pkg::COL_LIMIT;
        end
        else
        begin
            rows_in_use_reg <= rows_in_use_next;
            cols_in_use_reg <= cols_in_use_next;
        end
    end

    // Accept and classify
    wpsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .row_pos    (row_pos),
        .col_pos    (col_pos),
        .swapped    (swapped),
        .prob       (prob),
        .weight_one (weight_one),
        .weight_two (weight_two),
        .map_col    (map_col),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .ctl        (ctl),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    // Carry out commands against maps and matrix
    wpsa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .rows_in_use (rows_in_use_reg),
        .cols_in_use (cols_in_use_reg),
        .res_stat    (rq_stat),
        .ctl         (ctl),
        .res_push    (res_push),
        .res         (res)
    );

    // Hold results until popped
    wpsa_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .pop      (pop),
        .stat     (rq_stat),
        .res_out  (rq_head)
    );

    assign empty      = rq_stat.empty;
    assign cell_value = rq_head.value;
    assign status     = rq_head.status;

    // The sequencer only starts an item when its result has room waiting
    a_take_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> !rq_stat.full)
        else $error("command taken while result queue full");

    // No result is ever pushed into a full result queue
    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !rq_stat.full)
        else $error("result pushed into full queue");

    // A result pushed with nothing popped leaves the result side non-empty
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && !pop |=> !empty)
        else $error("pushed result not visible");

endmodule

@@ tb/sv/weighted_posterior_scatter_accumulate_tb.sv @@
// Self-checking testbench for the weighted posterior scatter-accumulate block.
// Depends on wpsa_pkg and the weighted_posterior_scatter_accumulate top level only.
// Predicts every transfer from its own copy of the matrix, the maps and the bounds.

module weighted_posterior_scatter_accumulate_tb;

    // Codes not covered by the package enum
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic       ST_OK          = 1'b0;
    localparam logic       ST_RANGE       = 1'b1;
    localparam logic [2:0] ADDR_ROWS      = 3'd0;
    localparam logic [2:0] ADDR_COLS      = 3'd4;

    // Q0.48 product to Q8.24 cell increment
    localparam logic [47:0] HALF_LSB = 48'h80_0000;
    localparam int          Q_SHIFT  = 24;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TOUCHED_MAX   = 64;
    localparam int PHASES        = 8;

    // Per phase: register settings (-1 picks a random legal count), idling, size, extras
    localparam int PH_ROWS  [PHASES] = '{256, 1, 0, 256, 511, 17, 256, -1};
    localparam int PH_COLS  [PHASES] = '{256, 1, 256, 256, 300, 200, 0, -1};
    localparam int PH_SEND  [PHASES] = '{0, 55, 0, 37, 0, 55, 0, 37};
    localparam int PH_RECV  [PHASES] = '{0, 0, 55, 37, 0, 0, 55, 37};
    localparam int PH_ITEMS [PHASES] = '{200, 150, 100, 600, 200, 200, 100, 200};
    localparam bit PH_CLEAR [PHASES] = '{0, 0, 1, 0, 0, 1, 0, 0};
    localparam bit PH_HOT   [PHASES] = '{0, 0, 0, 1, 0, 0, 0, 0};

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  row_pos;
        logic [7:0]  col_pos;
        logic        swapped;
        logic [15:0] prob;
        logic [15:0] weight_one;
        logic [15:0] weight_two;
        logic [7:0]  map_col;
        logic [7:0]  cell_row;
        logic [7:0]  cell_col;
    } wpsa_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } cell_reply_t;

    // DUT signals; every input starts at a known value
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    logic [2:0]  op         = '0;
    logic [7:0]  row_pos    = '0;
    logic [7:0]  col_pos    = '0;
    logic        swapped    = 1'b0;
    logic [15:0] prob       = '0;
    logic [15:0] weight_one = '0;
    logic [15:0] weight_two = '0;
    logic [7:0]  map_col    = '0;
    logic [7:0]  cell_row   = '0;
    logic [7:0]  cell_col   = '0;
    logic        empty;
    logic        pop        = 1'b0;
    logic [31:0] cell_value;
    logic        status;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    weighted_posterior_scatter_accumulate i_dut (.*);

    always #4 clk = ~clk;

    // Predictor state: the matrix, both maps and the register copies
    logic [31:0] cell_mem    [wpsa_pkg::CELL_DEPTH];
    logic [7:0]  model_map_a [wpsa_pkg::MAX_SEQ_LEN];
    logic [7:0]  model_map_b [wpsa_pkg::MAX_SEQ_LEN];
    logic [8:0]  rows_cfg = 9'd256;
    logic [8:0]  cols_cfg = 9'd256;

    // Stimulus state: what the generator knows about maps and bounds when it queues an item
    logic [7:0]  gen_map_a [wpsa_pkg::MAX_SEQ_LEN];
    logic [7:0]  gen_map_b [wpsa_pkg::MAX_SEQ_LEN];
    bit          gen_wr_a  [wpsa_pkg::MAX_SEQ_LEN];
    bit          gen_wr_b  [wpsa_pkg::MAX_SEQ_LEN];
    int          gen_rb = 256;
    int          gen_cb = 256;
    logic [15:0] touched_cells [$];
    logic [7:0]  hot_a_pos;
    logic [7:0]  hot_b_pos;

    wpsa_item_t  pending_items [$];
    cell_reply_t expected_replies [$];
    wpsa_item_t  cur_item;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Work out the reply of one accepted item and advance the predictor state
    function automatic cell_reply_t predict_cell_reply(input wpsa_item_t it);
        cell_reply_t reply;
        int unsigned rb;
        int unsigned cb;
        int unsigned r;
        int unsigned c;
        logic [7:0]  apos;
        logic [7:0]  bpos;
        logic [47:0] prod;
        logic [32:0] total;
        reply.value  = '0;
        reply.status = ST_OK;
        rb = (rows_cfg > wpsa_pkg::MAX_COLS) ? wpsa_pkg::MAX_COLS : rows_cfg;
        cb = (cols_cfg > wpsa_pkg::MAX_COLS) ? wpsa_pkg::MAX_COLS : cols_cfg;
        case (it.op)
            wpsa_pkg::OP_CLEAR:  foreach (cell_mem[i]) cell_mem[i] = '0;
            wpsa_pkg::OP_LOAD_A: model_map_a[it.row_pos] = it.map_col;
            wpsa_pkg::OP_LOAD_B: model_map_b[it.row_pos] = it.map_col;
            wpsa_pkg::OP_ACCUM:
            begin
                // swap the sides before the map lookup
                apos = it.swapped ? it.col_pos : it.row_pos;
                bpos = it.swapped ? it.row_pos : it.col_pos;
                r = model_map_a[apos];
                c = model_map_b[bpos];
                if (r >= rb || c >= cb)
                    reply.status = ST_RANGE;
                else
                begin
                    prod  = 48'(it.weight_one) * 48'(it.weight_two) * 48'(it.prob);
                    total = 33'(cell_mem[r * wpsa_pkg::MAX_COLS + c]) +
                            33'((prod + HALF_LSB) >> Q_SHIFT);
                    cell_mem[r * wpsa_pkg::MAX_COLS + c] =
                        total[32] ? 32'hFFFF_FFFF : total[31:0];
                end
            end
            wpsa_pkg::OP_READ:
            begin
                if (it.cell_row >= rb || it.cell_col >= cb)
                    reply.status = ST_RANGE;
                else
                    reply.value = cell_mem[it.cell_row * wpsa_pkg::MAX_COLS + it.cell_col];
            end
            default: ;
        endcase
        return reply;
    endfunction

    // ---------------------------------------------------------------
    // Driver: present the next pending item, hold it until the transfer
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                expected_replies.push_back(predict_cell_reply(cur_item));
            if (!push || !full)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item    = pending_items.pop_front();
                    push       <= 1'b1;
                    op         <= cur_item.op;
                    row_pos    <= cur_item.row_pos;
                    col_pos    <= cur_item.col_pos;
                    swapped    <= cur_item.swapped;
                    prob       <= cur_item.prob;
                    weight_one <= cur_item.weight_one;
                    weight_two <= cur_item.weight_two;
                    map_col    <= cur_item.map_col;
                    cell_row   <= cur_item.cell_row;
                    cell_col   <= cur_item.cell_col;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check each result transfer against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        cell_reply_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_replies.size() == 0)
                    note_mismatch("result with nothing pending", '0, cell_value);
                else
                begin
                    want = expected_replies.pop_front();
                    if (cell_value !== want.value)
                        note_mismatch("cell_value", want.value, cell_value);
                    if (status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(status));
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("weighted_posterior_scatter_accumulate_tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // Configuration port: write one register, then read it back
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [2:0] addr, input logic [8:0] value);
        logic [31:0] data;
        // drive junk above the register width; only the low 9 bits count
        data      = $urandom;
        data[8:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (addr == ADDR_ROWS)
            rows_cfg = value;
        else
            cols_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== 32'(value))
            note_mismatch("register readback", 32'(value), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Block until every queued item has come back, then let the pipeline settle
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_items.size() != 0 || push || expected_replies.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic wpsa_item_t random_item();
        logic [95:0] raw;
        wpsa_item_t  it;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(wpsa_item_t)-1:0];
        return it;
    endfunction

    function automatic wpsa_item_t shaped_item(input logic [2:0] code, input logic [7:0] rp,
                                               input logic [7:0] cp, input logic sw,
                                               input logic [15:0] pr, input logic [15:0] w1,
                                               input logic [15:0] w2, input logic [7:0] mc,
                                               input logic [7:0] cr, input logic [7:0] cc);
        wpsa_item_t it;
        it = '{code, rp, cp, sw, pr, w1, w2, mc, cr, cc};
        return it;
    endfunction

    // Queue one item and track the maps and touched cells it will produce
    task automatic queue_item(input wpsa_item_t it);
        logic [7:0] apos;
        logic [7:0] bpos;
        case (it.op)
            wpsa_pkg::OP_LOAD_A:
            begin
                gen_map_a[it.row_pos] = it.map_col;
                gen_wr_a[it.row_pos]  = 1'b1;
            end
            wpsa_pkg::OP_LOAD_B:
            begin
                gen_map_b[it.row_pos] = it.map_col;
                gen_wr_b[it.row_pos]  = 1'b1;
            end
            wpsa_pkg::OP_ACCUM:
            begin
                apos = it.swapped ? it.col_pos : it.row_pos;
                bpos = it.swapped ? it.row_pos : it.col_pos;
                if (int'(gen_map_a[apos]) < gen_rb && int'(gen_map_b[bpos]) < gen_cb)
                begin
                    if (touched_cells.size() < TOUCHED_MAX)
                        touched_cells.push_back({gen_map_a[apos], gen_map_b[bpos]});
                    else
                        touched_cells[$urandom_range(TOUCHED_MAX - 1)] =
                            {gen_map_a[apos], gen_map_b[bpos]};
                end
            end
            default: ;
        endcase
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] frac_value(input bit hot);
        int roll;
        roll = $urandom_range(99);
        if (hot)
            return (roll < 90) ? 16'hFFFF : 16'($urandom);
        if (roll < 15)
            return 16'hFFFF;
        if (roll < 25)
            return 16'h0000;
        if (roll < 30)
            return 16'($urandom_range(3));
        return 16'($urandom);
    endfunction

    // Find a written map position, optionally one whose column lies inside the bound
    function automatic bit pick_pos(input bit side_b, input bit in_bounds,
                                    output logic [7:0] pos);
        int lim;
        int p;
        lim = side_b ? gen_cb : gen_rb;
        pos = '0;
        for (int t = 0; t < 48; t++)
        begin
            p = $urandom_range(wpsa_pkg::MAX_SEQ_LEN - 1);
            if (side_b ? gen_wr_b[p] : gen_wr_a[p])
            begin
                if (!in_bounds || int'(side_b ? gen_map_b[p] : gen_map_a[p]) < lim)
                begin
                    pos = 8'(p);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // No usable position: load one at a random spot, with a column inside the bound when the bound is nonzero
    task automatic fallback_load(input bit side_b, output logic [7:0] pos);
        wpsa_item_t it;
        int         lim;
        lim   = side_b ? gen_cb : gen_rb;
        it    = random_item();
        it.op = side_b ? wpsa_pkg::OP_LOAD_B : wpsa_pkg::OP_LOAD_A;
        if (lim > 0)
            it.map_col = 8'($urandom_range(lim - 1));
        pos = it.row_pos;
        queue_item(it);
    endtask

    task automatic add_accum(input bit in_bounds, input bit hot);
        wpsa_item_t it;
        logic [7:0] apos;
        logic [7:0] bpos;
        if (hot)
        begin
            apos = hot_a_pos;
            bpos = hot_b_pos;
        end
        else
        begin
            if (!pick_pos(1'b0, in_bounds, apos))
                fallback_load(1'b0, apos);
            if (!pick_pos(1'b1, in_bounds, bpos))
                fallback_load(1'b1, bpos);
        end
        it            = random_item();
        it.op         = wpsa_pkg::OP_ACCUM;
        it.swapped    = 1'($urandom_range(1));
        it.row_pos    = it.swapped ? bpos : apos;
        it.col_pos    = it.swapped ? apos : bpos;
        it.prob       = frac_value(hot);
        it.weight_one = frac_value(hot);
        it.weight_two = frac_value(hot);
        queue_item(it);
    endtask

    task automatic add_read(input int roll);
        wpsa_item_t it;
        it    = random_item();
        it.op = wpsa_pkg::OP_READ;
        if (roll < 60 && touched_cells.size() != 0)
            {it.cell_row, it.cell_col} = touched_cells[$urandom_range(touched_cells.size() - 1)];
        else if (roll < 85 && gen_rb > 0 && gen_cb > 0)
        begin
            it.cell_row = 8'($urandom_range(gen_rb - 1));
            it.cell_col = 8'($urandom_range(gen_cb - 1));
        end
        queue_item(it);
    endtask

    task automatic add_load();
        wpsa_item_t it;
        int         lim;
        it    = random_item();
        it.op = $urandom_range(1) ? wpsa_pkg::OP_LOAD_B : wpsa_pkg::OP_LOAD_A;
        lim   = (it.op == wpsa_pkg::OP_LOAD_B) ? gen_cb : gen_rb;
        if ($urandom_range(1) && lim > 0)
            it.map_col = 8'($urandom_range(lim - 1));
        queue_item(it);
    endtask

    // One random phase: mostly mapped accumulates, reads of live cells, some noise
    task automatic gen_phase(input int count, input bit with_clear, input bit hot);
        wpsa_item_t it;
        int         roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (with_clear && i == count / 2)
            begin
                it    = random_item();
                it.op = wpsa_pkg::OP_CLEAR;
                queue_item(it);
            end
            else if (hot)
            begin
                // hammer one cell with near-maximum terms to reach saturation
                if (roll < 75)
                    add_accum(1'b1, $urandom_range(99) < 95);
                else if (roll < 95)
                    add_read($urandom_range(99));
                else
                begin
                    it    = random_item();
                    it.op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
                    queue_item(it);
                end
            end
            else if (roll < 45)
                add_accum(1'b1, 1'b0);
            else if (roll < 55)
                add_accum(1'b0, 1'b0);
            else if (roll < 75)
                add_read($urandom_range(99));
            else if (roll < 92)
                add_load();
            else
            begin
                it    = random_item();
                it.op = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
                queue_item(it);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence: reset, directed items, then random phases per setting
    // ---------------------------------------------------------------
    initial
    begin
        wpsa_item_t it;
        int         rows;
        int         cols;
        foreach (cell_mem[i]) cell_mem[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fresh matrix reads zero at both corners
        queue_item(shaped_item(wpsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
        queue_item(shaped_item(wpsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255, 8'd255));
        // Load map extremes before any accumulate looks them up
        queue_item(shaped_item(wpsa_pkg::OP_LOAD_A, 8'd0, 0, 0, 0, 0, 0, 8'd0, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_LOAD_A, 8'd255, 0, 0, 0, 0, 0, 8'd255, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_LOAD_A, 8'd1, 0, 0, 0, 0, 0, 8'd255, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_LOAD_B, 8'd0, 0, 0, 0, 0, 0, 8'd0, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_LOAD_B, 8'd255, 0, 0, 0, 0, 0, 8'd255, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_LOAD_B, 8'd1, 0, 0, 0, 0, 0, 8'd0, 0, 0));
        // Full-scale terms into both corners, one straight and one swapped
        queue_item(shaped_item(wpsa_pkg::OP_ACCUM, 8'd0, 8'd0, 1'b0,
                               16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_ACCUM, 8'd255, 8'd255, 1'b1,
                               16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        // Swapped lookup; product of exactly one half LSB rounds up
        queue_item(shaped_item(wpsa_pkg::OP_ACCUM, 8'd0, 8'd1, 1'b1,
                               16'h0080, 16'h0100, 16'h0100, 0, 0, 0));
        // Zero probability adds nothing
        queue_item(shaped_item(wpsa_pkg::OP_ACCUM, 8'd1, 8'd1, 1'b0,
                               16'h0000, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        // Smallest nonzero terms round away
        queue_item(shaped_item(wpsa_pkg::OP_ACCUM, 8'd0, 8'd1, 1'b0,
                               16'h0001, 16'h0001, 16'h0001, 0, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
        queue_item(shaped_item(wpsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255, 8'd255));
        queue_item(shaped_item(wpsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255, 8'd0));
        // Unused codes do nothing
        for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
        begin
            it    = random_item();
            it.op = 3'(code);
            queue_item(it);
        end
        queue_item(shaped_item(wpsa_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_item(shaped_item(wpsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0));
        queue_item(shaped_item(wpsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255, 8'd0));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // registers change only with the block idle
            wait_drained();
            rows = (PH_ROWS[ph] < 0) ? $urandom_range(wpsa_pkg::MAX_COLS, 1) : PH_ROWS[ph];
            cols = (PH_COLS[ph] < 0) ? $urandom_range(wpsa_pkg::MAX_COLS, 1) : PH_COLS[ph];
            write_reg(ADDR_ROWS, 9'(rows));
            write_reg(ADDR_COLS, 9'(cols));
            gen_rb         = (rows > wpsa_pkg::MAX_COLS) ? wpsa_pkg::MAX_COLS : rows;
            gen_cb         = (cols > wpsa_pkg::MAX_COLS) ? wpsa_pkg::MAX_COLS : cols;
            send_idle_pct  = PH_SEND[ph];
            recv_stall_pct = PH_RECV[ph];
            @(negedge clk);
            if (PH_HOT[ph])
            begin
                // point one A and one B position at cell (0,0)
                hot_a_pos = 8'($urandom);
                hot_b_pos = 8'($urandom);
                queue_item(shaped_item(wpsa_pkg::OP_LOAD_A, hot_a_pos, 0, 0, 0, 0, 0,
                                       8'd0, 0, 0));
                queue_item(shaped_item(wpsa_pkg::OP_LOAD_B, hot_b_pos, 0, 0, 0, 0, 0,
                                       8'd0, 0, 0));
            end
            gen_phase(PH_ITEMS[ph], PH_CLEAR[ph], PH_HOT[ph]);
        end

        wait_drained();
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("weighted_posterior_scatter_accumulate_tb: clean");
        else
            $display("weighted_posterior_scatter_accumulate_tb: errors");
        $finish;
    end

endmodule
